>>> rtl/hpbw_pkg.sv
// Shared constants and controller/datapath types for the half-power beamwidth finder.
package hpbw_pkg;

  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned DROP_W          = 15;
  localparam int unsigned NUM_W           = 17;
  localparam int unsigned POS_W           = 20;
  localparam int unsigned CNT_OUT_W       = 13;
  localparam int unsigned DEF_MAX_SAMPLES = 4096;
  localparam int unsigned DEF_FRAC_BITS   = 8;
  localparam logic [DROP_W-1:0] DROP_RESET = 15'd768;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_right;
    logic calc_pos;
    logic calc_dist;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

>>> rtl/hpbw_if.sv
// Channel interfaces: sample input, result output, configuration write.
interface hpbw_smp_if import hpbw_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface hpbw_res_if import hpbw_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [POS_W-1:0]           left_pos;
  logic [POS_W-1:0]           right_pos;
  logic signed [SAMPLE_W-1:0] peak_out;
  logic [POS_W-1:0]           width_samples;
  logic [CNT_OUT_W-1:0]       sample_count;
  logic                       too_long;

  modport source (output valid, output found, output left_pos, output right_pos,
                  output peak_out, output width_samples, output sample_count,
                  output too_long, input ready);
  modport sink (input valid, input found, input left_pos, input right_pos,
                input peak_out, input width_samples, input sample_count,
                input too_long, output ready);
endinterface

interface hpbw_cfg_if import hpbw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DROP_W-1:0] drop_level;

  modport source (output valid, output drop_level, input ready);
  modport sink (input valid, input drop_level, output ready);
endinterface

>>> rtl/hpbw_div.sv
// Iterative restoring divider: (num << FRAC_BITS) / den, one quotient bit per cycle.
module hpbw_div import hpbw_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [NUM_W-1:0] den_i,
  output logic             done_o,
  output logic [FRAC_BITS:0] quot_o
);

  localparam int unsigned STEPS = FRAC_BITS + 1;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [NUM_W:0]     rem_q;
  logic [NUM_W-1:0]   den_q;
  logic [FRAC_BITS:0] quot_q;
  logic [CW-1:0]      cnt_q;
  logic               done_q;

  logic           ge;
  logic [NUM_W:0] diff;
  logic [NUM_W:0] rem_sel;

  assign ge      = rem_q >= {1'b0, den_q};
  assign diff    = rem_q - {1'b0, den_q};
  assign rem_sel = ge ? diff : rem_q;

  // remainder stays below den, so the shifted-out top bit is always zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(STEPS);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CW'(1);
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= {rem_sel[NUM_W-1:0], 1'b0};
      quot_q <= {quot_q[FRAC_BITS-1:0], ge};
    end
  end

  // zero denominator only comes with a zero numerator: fraction is zero
  assign quot_o = (den_q == '0) ? '0 : quot_q;
  assign done_o = done_q;

endmodule

>>> rtl/hpbw_datapath.sv
// Datapath: per-sample crossing tracking, shared divider, position and width math.
module hpbw_datapath import hpbw_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       cfg_we_i,
  input  logic [DROP_W-1:0]          cfg_drop_i,
  output logic                       found_o,
  output logic [POS_W-1:0]           left_pos_o,
  output logic [POS_W-1:0]           right_pos_o,
  output logic signed [SAMPLE_W-1:0] peak_out_o,
  output logic [POS_W-1:0]           width_samples_o,
  output logic [CNT_OUT_W-1:0]       sample_count_o,
  output logic                       too_long_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned PW    = CNT_W + FRAC_BITS;

  // pattern state
  logic [DROP_W-1:0]          drop_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [SAMPLE_W-1:0] peak_q;
  logic signed [NUM_W-1:0]    thr_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic                       left_seen_q;
  logic [IDX_W-1:0]           left_idx_q;
  logic [NUM_W-1:0]           left_num_q;
  logic [NUM_W-1:0]           left_den_q;
  logic [IDX_W-1:0]           right_idx_q;
  logic [NUM_W-1:0]           right_num_q;
  logic signed [SAMPLE_W-1:0] right_cross_q;
  logic signed [SAMPLE_W-1:0] right_smp_q;
  logic                       right_wait_q;
  logic                       ovf_q;

  // wrap-up state
  logic [FRAC_BITS:0] frac_l_q;
  logic [FRAC_BITS:0] frac_r_q;
  logic [PW-1:0]      lpos_q;
  logic [PW-1:0]      rpos_q;
  logic [PW-1:0]      dist_q;

  // per-sample compares
  logic signed [NUM_W-1:0]    s_ext;
  logic signed [NUM_W-1:0]    thr_new;
  logic                       below;
  logic [NUM_W-1:0]           num_new;
  logic [NUM_W-1:0]           pden_new;
  logic                       in_room;

  assign s_ext    = {sample_i[SAMPLE_W-1], sample_i};
  assign thr_new  = s_ext - $signed({2'b00, drop_q});
  assign below    = s_ext <= thr_q;
  assign num_new  = thr_q - s_ext;
  assign pden_new = {prev_q[SAMPLE_W-1], prev_q} - s_ext;
  assign in_room  = cnt_q < CNT_W'(MAX_SAMPLES);

  // divider operands
  logic signed [SAMPLE_W-1:0] succ;
  logic [NUM_W-1:0]           rden;
  logic [NUM_W-1:0]           div_num;
  logic [NUM_W-1:0]           div_den;
  logic                       div_done;
  logic [FRAC_BITS:0]         quot;

  assign succ    = right_wait_q ? peak_q : right_smp_q;
  assign rden    = {succ[SAMPLE_W-1], succ} - {right_cross_q[SAMPLE_W-1], right_cross_q};
  assign div_num = cmd_i.div_right ? right_num_q : left_num_q;
  assign div_den = cmd_i.div_right ? rden : left_den_q;

  hpbw_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign status_o.div_done = div_done;

  // position math
  logic [PW-1:0] full;
  logic [PW-1:0] lpos_d;
  logic [PW-1:0] rsum;
  logic [PW-1:0] rpos_d;
  logic [PW-1:0] dist_d;
  logic [PW-1:0] comp;
  logic [PW-1:0] width_d;

  assign full    = PW'(cnt_q) << FRAC_BITS;
  assign lpos_d  = (PW'(left_idx_q) << FRAC_BITS) - PW'(frac_l_q);
  assign rsum    = (PW'(right_idx_q) << FRAC_BITS) + PW'(frac_r_q);
  assign rpos_d  = (rsum >= full) ? rsum - full : rsum;
  assign dist_d  = (lpos_q > rpos_q) ? lpos_q - rpos_q : rpos_q - lpos_q;
  assign comp    = full - dist_q;
  assign width_d = (dist_q <= comp) ? dist_q : comp;

  logic [PW+POS_W-1:0]        lpos_ext;
  logic [PW+POS_W-1:0]        rpos_ext;
  logic [PW+POS_W-1:0]        width_ext;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign lpos_ext  = {{POS_W{1'b0}}, lpos_q};
  assign rpos_ext  = {{POS_W{1'b0}}, rpos_q};
  assign width_ext = {{POS_W{1'b0}}, width_d};
  assign cnt_ext   = {{CNT_OUT_W{1'b0}}, cnt_q};

  // control state of the pattern
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q       <= DROP_RESET;
      cnt_q        <= '0;
      left_seen_q  <= 1'b0;
      right_wait_q <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        drop_q <= cfg_drop_i;
      end
      if (cmd_i.load_out) begin
        cnt_q        <= '0;
        left_seen_q  <= 1'b0;
        right_wait_q <= 1'b0;
        ovf_q        <= 1'b0;
      end else if (cmd_i.accept) begin
        if (in_room) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q != '0) begin
            if (below) begin
              left_seen_q  <= 1'b1;
              right_wait_q <= 1'b1;
            end else if (right_wait_q) begin
              right_wait_q <= 1'b0;
            end
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // payload of the pattern and wrap-up
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_room) begin
      prev_q <= sample_i;
      if (cnt_q == '0) begin
        peak_q <= sample_i;
        thr_q  <= thr_new;
      end else if (below) begin
        if (!left_seen_q) begin
          left_idx_q <= cnt_q[IDX_W-1:0];
          left_num_q <= num_new;
          left_den_q <= pden_new;
        end
        right_idx_q   <= cnt_q[IDX_W-1:0];
        right_num_q   <= num_new;
        right_cross_q <= sample_i;
      end else if (right_wait_q) begin
        right_smp_q <= sample_i;
      end
    end
    if (div_done) begin
      if (cmd_i.div_right) begin
        frac_r_q <= quot;
      end else begin
        frac_l_q <= quot;
      end
    end
    if (cmd_i.calc_pos) begin
      lpos_q <= left_seen_q ? lpos_d : '0;
      rpos_q <= left_seen_q ? rpos_d : '0;
    end
    if (cmd_i.calc_dist) begin
      dist_q <= dist_d;
    end
    if (cmd_i.load_out) begin
      found_o         <= left_seen_q;
      left_pos_o      <= lpos_ext[POS_W-1:0];
      right_pos_o     <= rpos_ext[POS_W-1:0];
      peak_out_o      <= peak_q;
      width_samples_o <= width_ext[POS_W-1:0];
      sample_count_o  <= cnt_ext[CNT_OUT_W-1:0];
      too_long_o      <= ovf_q;
    end
  end

endmodule

>>> rtl/hpbw_ctrl.sv
// Controller: sample phase, two divisions, position and width steps, result handoff.
module hpbw_ctrl import hpbw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DIV_L,
    ST_DIV_R,
    ST_POS,
    ST_DIST,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   start_q;
  logic   right_q;
  logic   out_valid_q;

  logic accept;
  logic load;

  assign accept = (state_q == ST_RUN) && in_valid_i;
  // output register is free or being emptied this cycle
  assign load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.div_start = start_q;
    cmd_o.div_right = right_q;
    cmd_o.calc_pos  = (state_q == ST_POS);
    cmd_o.calc_dist = (state_q == ST_DIST);
    cmd_o.load_out  = load;
  end

  assign in_ready_o  = (state_q == ST_RUN);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      start_q     <= 1'b0;
      right_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end
      case (state_q)
        ST_RUN: begin
          if (accept && in_last_i) begin
            state_q <= ST_DIV_L;
            start_q <= 1'b1;
            right_q <= 1'b0;
          end
        end
        ST_DIV_L: begin
          if (status_i.div_done) begin
            state_q <= ST_DIV_R;
            start_q <= 1'b1;
            right_q <= 1'b1;
          end
        end
        ST_DIV_R: begin
          if (status_i.div_done) begin
            state_q <= ST_POS;
          end
        end
        ST_POS: begin
          state_q <= ST_DIST;
        end
        ST_DIST: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (load) begin
            state_q <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

endmodule

>>> rtl/half_power_beamwidth_finder.sv
// Half-power beamwidth finder top level: controller, datapath and channel ports.
//
// A pattern streams in one dB sample per word on smp, first word being the
// peak; threshold is peak minus drop_level (unsigned Q7.8 dB, reset 3 dB,
// written on cfg, which is always ready). Samples are taken one per cycle in
// the sample phase. The word marked last closes the pattern: the block then
// stops taking samples until its result is loaded, while the single shared
// restoring divider runs FRAC_BITS+1 quotient steps for the left crossing and
// again for the right one, followed by a position step and a distance step;
// width is worked out as the output register loads. The result word sits in
// that register; the next pattern may stream in while it waits to be taken,
// and only the following wrap-up waits on it. Samples beyond MAX_SAMPLES are
// dropped and flagged in too_long. Positions and width carry FRAC_BITS
// fraction bits and are cut to 20 bits; sample_count is cut to 13 bits.
module half_power_beamwidth_finder import hpbw_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hpbw_smp_if.sink   smp,
  hpbw_res_if.source res,
  hpbw_cfg_if.sink   cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register write never stalls
  assign cfg.ready = 1'b1;

  hpbw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp.valid),
    .in_last_i  (smp.last),
    .in_ready_o (smp.ready),
    .out_ready_i(res.ready),
    .out_valid_o(res.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hpbw_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (smp.sample),
    .cfg_we_i       (cfg.valid),
    .cfg_drop_i     (cfg.drop_level),
    .found_o        (res.found),
    .left_pos_o     (res.left_pos),
    .right_pos_o    (res.right_pos),
    .peak_out_o     (res.peak_out),
    .width_samples_o(res.width_samples),
    .sample_count_o (res.sample_count),
    .too_long_o     (res.too_long)
  );

`ifndef SYNTH
  // a pattern with no crossing reports zero positions and width
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> (res.found ||
      (res.left_pos == '0 && res.right_pos == '0 && res.width_samples == '0)))
    else $error("no-crossing result carries nonzero position");

  // divider results arrive only while sample intake is closed
  a_div_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> !smp.ready)
    else $error("divider finished during sample phase");

  // loading the output register presents a result word next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> res.valid)
    else $error("result load without valid");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the half-power beamwidth finder.
module testbench;
  import hpbw_pkg::*;

  localparam int FRAC    = DEF_FRAC_BITS;
  localparam int MAX_CNT = DEF_MAX_SAMPLES;
  // Settling wait after a drain: covers the wrap-up and the output register.
  localparam int WRAP_LAT = 2 * FRAC + 9 + 8;

  typedef struct {
    logic                       found;
    logic [POS_W-1:0]           left_pos;
    logic [POS_W-1:0]           right_pos;
    logic signed [SAMPLE_W-1:0] peak_out;
    logic [POS_W-1:0]           width_samples;
    logic [CNT_OUT_W-1:0]       sample_count;
    logic                       too_long;
  } beam_result_t;

  logic clk_i;
  logic rst_ni;

  hpbw_smp_if smp_ch ();
  hpbw_res_if res_ch ();
  hpbw_cfg_if cfg_ch ();

  half_power_beamwidth_finder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp    (smp_ch),
    .res    (res_ch),
    .cfg    (cfg_ch)
  );

  // Predicted beam results, oldest first.
  beam_result_t expected_beams[$];
  int           mismatch_count;
  int           res_stall;
  bit           idle_on;

  // Predictor copy of the drop register and of the per-pattern tracking state.
  logic [DROP_W-1:0]          drop_setting;
  logic [CNT_OUT_W-1:0]       beam_count;
  logic signed [SAMPLE_W-1:0] beam_peak;
  logic signed [NUM_W-1:0]    beam_thr;
  logic signed [SAMPLE_W-1:0] beam_prev;
  logic                       left_hit;
  logic [11:0]                left_idx;
  logic [NUM_W-1:0]           left_num;
  logic [NUM_W-1:0]           left_den;
  logic [11:0]                right_idx;
  logic [NUM_W-1:0]           right_num;
  logic signed [SAMPLE_W-1:0] right_after;
  logic                       right_open;
  logic                       beam_dropped;

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic void clear_beam();
    beam_count   = '0;
    beam_peak    = '0;
    beam_thr     = '0;
    beam_prev    = '0;
    left_hit     = 1'b0;
    left_idx     = '0;
    left_num     = '0;
    left_den     = '0;
    right_idx    = '0;
    right_num    = '0;
    right_after  = '0;
    right_open   = 1'b0;
    beam_dropped = 1'b0;
  endfunction

  // Truncated (num << FRAC) / den, clamped to one; zero den gives zero.
  function automatic longint crossing_frac(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    q = (num << FRAC) / den;
    if (q > (longint'(1) << FRAC)) q = longint'(1) << FRAC;
    return q;
  endfunction

  // Advance the tracking state by one accepted word; on last, queue the
  // predicted result and start over.
  function automatic void track_sample(logic signed [SAMPLE_W-1:0] s, bit lst);
    int           sv;
    int           thr_i;
    int           succ_i;
    int           cross_i;
    longint       full;
    longint       lpos;
    longint       rpos;
    longint       gap;
    longint       width;
    beam_result_t r;
    sv    = int'(s);
    thr_i = int'(beam_thr);
    if (beam_count < MAX_CNT) begin
      if (beam_count == 0) begin
        beam_peak = s;
        beam_thr  = NUM_W'(sv - int'(drop_setting));
      end else if (sv <= thr_i) begin
        // first crossing keeps its predecessor, every crossing moves the right edge
        if (!left_hit) begin
          left_hit = 1'b1;
          left_idx = beam_count[11:0];
          left_num = NUM_W'(thr_i - sv);
          left_den = NUM_W'(int'(beam_prev) - sv);
        end
        right_idx  = beam_count[11:0];
        right_num  = NUM_W'(thr_i - sv);
        right_open = 1'b1;
      end else if (right_open) begin
        right_after = s;
        right_open  = 1'b0;
      end
      beam_prev  = s;
      beam_count = beam_count + 1'b1;
    end else begin
      beam_dropped = 1'b1;
    end
    if (!lst) return;

    full  = longint'(beam_count) << FRAC;
    lpos  = 0;
    rpos  = 0;
    width = 0;
    if (left_hit) begin
      // successor of the last crossing wraps round to the peak when no word follows it
      succ_i  = right_open ? int'(beam_peak) : int'(right_after);
      cross_i = int'(beam_thr) - int'(right_num);
      lpos = (longint'(left_idx) << FRAC)
             - crossing_frac(longint'(left_num), longint'(left_den));
      rpos = (longint'(right_idx) << FRAC)
             + crossing_frac(longint'(right_num), longint'(succ_i - cross_i));
      if (rpos >= full) rpos = rpos - full;
      gap   = (lpos > rpos) ? lpos - rpos : rpos - lpos;
      width = (gap <= full - gap) ? gap : full - gap;
    end
    r.found         = left_hit;
    r.left_pos      = lpos[POS_W-1:0];
    r.right_pos     = rpos[POS_W-1:0];
    r.peak_out      = beam_peak;
    r.width_samples = width[POS_W-1:0];
    r.sample_count  = beam_count;
    r.too_long      = beam_dropped;
    expected_beams.push_back(r);
    clear_beam();
  endfunction

  function automatic int clamp_level(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: compare each taken word with the oldest prediction, and
  // stall ready in random bursts while idling is on.
  always @(posedge clk_i) begin
    beam_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_beams.size() == 0) begin
        $display("%0t: result word with none expected, expected none actual count %0d",
                 $time, res_ch.sample_count);
        mismatch_count++;
      end else begin
        want = expected_beams.pop_front();
        check_field("found", longint'(want.found), longint'(res_ch.found));
        check_field("left_pos", longint'(want.left_pos), longint'(res_ch.left_pos));
        check_field("right_pos", longint'(want.right_pos), longint'(res_ch.right_pos));
        check_field("peak_out", longint'(want.peak_out), longint'(res_ch.peak_out));
        check_field("width_samples", longint'(want.width_samples),
                    longint'(res_ch.width_samples));
        check_field("sample_count", longint'(want.sample_count),
                    longint'(res_ch.sample_count));
        check_field("too_long", longint'(want.too_long), longint'(res_ch.too_long));
      end
    end
    if (res_stall > 0) begin
      res_ch.ready <= 1'b0;
      res_stall--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      res_stall = $urandom_range(0, 13);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Send one sample word; optional idle burst first, then hold until taken.
  task automatic send_sample(input int level, input bit lst);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      smp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    smp_ch.valid  <= 1'b1;
    smp_ch.sample <= level[SAMPLE_W-1:0];
    smp_ch.last   <= lst;
    @(posedge clk_i);
    while (!smp_ch.ready) @(posedge clk_i);
    track_sample(level[SAMPLE_W-1:0], lst);
  endtask

  task automatic send_pattern(input int levels[$]);
    foreach (levels[i]) send_sample(levels[i], i == levels.size() - 1);
  endtask

  // Stop sending and wait for every predicted result, then let wrap-up settle.
  task automatic drain_results();
    int guard;
    guard = 0;
    smp_ch.valid <= 1'b0;
    while (expected_beams.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (WRAP_LAT) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_drop(input logic [DROP_W-1:0] val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.drop_level <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    drop_setting = val;
  endtask

  // One random pattern: mostly beam-like levels around the threshold,
  // sometimes raw noise; returns the number of words sent.
  task automatic send_random_pattern(output int len);
    int peak;
    int span;
    int lvl;
    int pick;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
    peak = int'($urandom_range(0, 65535)) - 32768;
    span = 2 * int'(drop_setting) + 512;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 7);
      if (i == 0) lvl = peak;
      else if (pick == 0) lvl = clamp_level(peak - int'(drop_setting));
      else if (pick == 1) lvl = int'($urandom_range(0, 65535)) - 32768;
      else lvl = clamp_level(peak - int'($urandom_range(0, span)));
      send_sample(lvl, i == len - 1);
    end
  endtask

  // Patterns of one word: count 1, nothing found, peak extremes.
  task automatic test_single_sample();
    send_pattern({32767});
    send_pattern({-32768});
    send_pattern({0});
  endtask

  // Default 3 dB drop: plain main lobe, several lobes, a crossing on the
  // final word that wraps to the peak, and a pattern that never crosses.
  task automatic test_crossings();
    send_pattern({0, -256, -1024, -2048, -1024, -256});
    send_pattern({0, -800, -100, -900, -50});
    send_pattern({0, -256, -1000});
    send_pattern({0, -100, -767, -200});
  endtask

  // Zero drop: zero denominators and a right edge that lands exactly on
  // the wrap point and reads back as zero.
  task automatic test_zero_drop();
    drain_results();
    write_drop('0);
    send_pattern({100, 100});
    send_pattern({100, 50, 20});
    send_pattern({100, 200, 100});
  endtask

  // Largest drop with full-scale levels.
  task automatic test_extremes();
    drain_results();
    write_drop(15'h7fff);
    send_pattern({32767, -32768});
    send_pattern({-32768, 32767, -32768});
    send_pattern({32767, 0, -32768, 32767});
    drain_results();
    write_drop(DROP_RESET);
  endtask

  // Random patterns over several drop settings; each change waits for the
  // block to drain first.
  task automatic test_random_patterns();
    int sent;
    int phase_items;
    logic [DROP_W-1:0] next_drop;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: next_drop = '0;
        1: next_drop = 15'h7fff;
        2: next_drop = DROP_RESET;
        3: next_drop = DROP_W'($urandom_range(1, 2048));
        4: next_drop = DROP_W'($urandom_range(0, 32767));
        default: next_drop = 15'd1;
      endcase
      drain_results();
      write_drop(next_drop);
      phase_items = 0;
      while (phase_items < 235) begin
        send_random_pattern(sent);
        phase_items += sent;
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    int sent;
    int total;
    drain_results();
    write_drop(DROP_RESET);
    idle_on = 1'b0;
    total = 0;
    while (total < 200) begin
      send_random_pattern(sent);
      total += sent;
    end
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    smp_ch.valid      = 1'b0;
    smp_ch.sample     = '0;
    smp_ch.last       = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.drop_level = '0;
    res_ch.ready      = 1'b0;
    mismatch_count    = 0;
    res_stall         = 0;
    idle_on           = 1'b1;
    drop_setting      = DROP_RESET;
    clear_beam();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sample();
    test_crossings();
    test_zero_drop();
    test_extremes();
    test_random_patterns();
    test_steady_stream();

    drain_results();
    if (expected_beams.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0",
               $time, expected_beams.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
